// ----- src/clipped_thick_line_rasterizer_assert.svh -----
// Assertion macros used by the rasterizer top level.
`ifndef CLIPPED_THICK_LINE_RASTERIZER_ASSERT_SVH
`define CLIPPED_THICK_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CTLR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CTLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ctlr_pkg.sv -----
// Types and constants for the clipped thick line rasterizer.
package ctlr_pkg;

  localparam int COORD_BITS    = 12;  // stored positions, spans, config values
  localparam int CALC_BITS     = 14;  // signed endpoint and pixel arithmetic
  localparam int COLOR_BITS    = 32;
  localparam int PEN_BITS      = 3;
  localparam int OFF_BITS      = 3;   // square offset counter, 0..2h
  localparam int ERR_BITS      = 2 * COORD_BITS + 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int MAX_PEN_WIDTH = 7;

  localparam int IN_DATA_BITS  = 4 * CALC_BITS + COLOR_BITS;
  localparam int OUT_DATA_BITS = 2 * COORD_BITS + COLOR_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_LEFT_MARGIN   = 3'd2,
    CFG_RIGHT_MARGIN  = 3'd3,
    CFG_TOP_MARGIN    = 3'd4,
    CFG_BOTTOM_MARGIN = 3'd5,
    CFG_PEN_WIDTH     = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_DRAW  = 1'b1
  } func_e;

  // Line setup computed from a start item
  typedef struct packed {
    logic [COORD_BITS-1:0] major_pos;
    logic [COORD_BITS-1:0] minor_pos;
    logic [COORD_BITS-1:0] major_end;
    logic [COORD_BITS-1:0] minor_end;
    logic                  major_dir;
    logic                  minor_dir;
    logic                  steep;
    logic [COORD_BITS-1:0] major_span;
    logic [COORD_BITS-1:0] minor_span;
  } line_t;

endpackage

// ----- src/ctlr_line_setup.sv -----
// Start-of-line setup: endpoint clamp, axis swap, spans and step directions.
module ctlr_line_setup import ctlr_pkg::*; (
  input  logic signed [CALC_BITS-1:0] x_start_i,
  input  logic signed [CALC_BITS-1:0] y_start_i,
  input  logic signed [CALC_BITS-1:0] x_end_i,
  input  logic signed [CALC_BITS-1:0] y_end_i,
  input  logic signed [CALC_BITS-1:0] x_lo_i,
  input  logic signed [CALC_BITS-1:0] x_hi_i,
  input  logic signed [CALC_BITS-1:0] y_lo_i,
  input  logic signed [CALC_BITS-1:0] y_hi_i,
  output line_t                       line_o
);

  // Low bound wins when the value is below it, even if the window is inverted
  function automatic logic signed [CALC_BITS-1:0] clamp(
    input logic signed [CALC_BITS-1:0] v,
    input logic signed [CALC_BITS-1:0] lo,
    input logic signed [CALC_BITS-1:0] hi
  );
    logic signed [CALC_BITS-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CALC_BITS-1:0] absdiff(
    input logic signed [CALC_BITS-1:0] a,
    input logic signed [CALC_BITS-1:0] b
  );
    logic signed [CALC_BITS-1:0] r;
    r = (a > b) ? (a - b) : (b - a);
    return r;
  endfunction

  logic signed [CALC_BITS-1:0] x1, x2, y1, y2;
  logic signed [CALC_BITS-1:0] a1, a2, b1, b2;
  logic [CALC_BITS-1:0]        dx, dy;
  logic                        steep;

  assign x1 = clamp(x_start_i, x_lo_i, x_hi_i);
  assign x2 = clamp(x_end_i, x_lo_i, x_hi_i);
  assign y1 = clamp(y_start_i, y_lo_i, y_hi_i);
  assign y2 = clamp(y_end_i, y_lo_i, y_hi_i);

  assign dx = absdiff(x1, x2);
  assign dy = absdiff(y1, y2);

  // Steep lines step along rows
  assign steep = (dy > dx);
  assign a1 = steep ? y1 : x1;
  assign a2 = steep ? y2 : x2;
  assign b1 = steep ? x1 : y1;
  assign b2 = steep ? x2 : y2;

  always_comb begin
    line_o.major_pos  = a1[COORD_BITS-1:0];
    line_o.major_end  = a2[COORD_BITS-1:0];
    line_o.minor_pos  = b1[COORD_BITS-1:0];
    line_o.minor_end  = b2[COORD_BITS-1:0];
    line_o.major_dir  = !(a1 < a2);
    line_o.minor_dir  = !(b1 < b2);
    line_o.steep      = steep;
    line_o.major_span = steep ? dy[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    line_o.minor_span = steep ? dx[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  end

endmodule

// ----- src/clipped_thick_line_rasterizer.sv -----
// Top level of the clipped thick line rasterizer.
//
// A start item (tuser = 0) sets up a line and produces no result. A draw
// item (tuser = 1) produces (2*(pen_width/2)+1)^2 pixel transfers, 1 to 49,
// one per cycle while the master side does not stall; a draw item with no
// line active produces a single transfer. The pixel offset counter feeding
// the output register sets the count, and a stall on the master side holds
// the input item, since input ready follows output ready in the same
// cycle. Pixels outside the clip window come out with pixel_write low and
// zero coordinates. Configuration writes are taken at any time but must only
// be issued while the block is idle.
`include "clipped_thick_line_rasterizer_assert.svh"

module clipped_thick_line_rasterizer import ctlr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [COORD_BITS-1:0]    cfg_data_i,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // x_start[13:0], y_start[27:14], x_end[41:28], y_end[55:42], color[87:56]
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // func[0]
  input  logic [0:0]               s_axis_tuser,
  // output stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // pixel_x[11:0], pixel_y[23:12], pixel_color[55:24]
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  // pixel_write[0], line_done[1]
  output logic [1:0]               m_axis_tuser,
  output logic                     m_axis_tlast
);

  // Configuration registers
  logic [COORD_BITS-1:0] img_w_q, img_h_q, left_q, right_q, top_q, bottom_q;
  logic [PEN_BITS-1:0]   pen_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q  <= COORD_BITS'(1024);
      img_h_q  <= COORD_BITS'(1024);
      left_q   <= '0;
      right_q  <= '0;
      top_q    <= '0;
      bottom_q <= '0;
      pen_q    <= PEN_BITS'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:   img_w_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT:  img_h_q  <= cfg_data_i;
        CFG_LEFT_MARGIN:   left_q   <= cfg_data_i;
        CFG_RIGHT_MARGIN:  right_q  <= cfg_data_i;
        CFG_TOP_MARGIN:    top_q    <= cfg_data_i;
        CFG_BOTTOM_MARGIN: bottom_q <= cfg_data_i;
        CFG_PEN_WIDTH:     pen_q    <= cfg_data_i[PEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Window bounds, signed
  localparam int PADW = CALC_BITS - COORD_BITS;
  logic signed [CALC_BITS-1:0] x_lo, x_hi, y_lo, y_hi;
  assign x_lo = $signed({{PADW{1'b0}}, left_q});
  assign y_lo = $signed({{PADW{1'b0}}, top_q});
  assign x_hi = $signed({{PADW{1'b0}}, img_w_q}) - $signed({{PADW{1'b0}}, right_q});
  assign y_hi = $signed({{PADW{1'b0}}, img_h_q}) - $signed({{PADW{1'b0}}, bottom_q});

  // Pen half size
  logic [PEN_BITS-1:0] pen_lim;
  logic [OFF_BITS-1:0] half, two_half;
  assign pen_lim  = (pen_q > PEN_BITS'(MAX_PEN_WIDTH)) ? PEN_BITS'(MAX_PEN_WIDTH) : pen_q;
  assign half     = OFF_BITS'(pen_lim >> 1);
  assign two_half = OFF_BITS'({half, 1'b0});

  // Input item register
  logic                        item_valid_q;
  logic                        item_func_q;
  logic signed [CALC_BITS-1:0] xs_q, ys_q, xe_q, ye_q;
  logic [COLOR_BITS-1:0]       item_color_q;

  logic out_free, item_consume, is_start, pix_last, emit;

  assign is_start      = (item_func_q == FUNC_START);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = item_valid_q && !is_start && out_free;
  assign item_consume  = item_valid_q && (is_start || (out_free && pix_last));
  assign s_axis_tready = !item_valid_q || item_consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_func_q  <= s_axis_tuser[0];
      xs_q         <= s_axis_tdata[CALC_BITS-1:0];
      ys_q         <= s_axis_tdata[2*CALC_BITS-1:CALC_BITS];
      xe_q         <= s_axis_tdata[3*CALC_BITS-1:2*CALC_BITS];
      ye_q         <= s_axis_tdata[4*CALC_BITS-1:3*CALC_BITS];
      item_color_q <= s_axis_tdata[IN_DATA_BITS-1:4*CALC_BITS];
    end
  end

  // Line setup from the held start item
  line_t setup;

  ctlr_line_setup u_setup (
    .x_start_i (xs_q),
    .y_start_i (ys_q),
    .x_end_i   (xe_q),
    .y_end_i   (ye_q),
    .x_lo_i    (x_lo),
    .x_hi_i    (x_hi),
    .y_lo_i    (y_lo),
    .y_hi_i    (y_hi),
    .line_o    (setup)
  );

  // Line state
  line_t                       line_q;
  logic signed [ERR_BITS-1:0]  err_q;
  logic                        drawing_q;
  logic [COLOR_BITS-1:0]       color_q;
  logic [OFF_BITS-1:0]         ci_q, cj_q;

  // Square offset sequencer: column offset outer, row offset inner
  logic sq_last;
  assign sq_last  = (ci_q == two_half) && (cj_q == two_half);
  assign pix_last = !drawing_q || sq_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q <= '0;
      cj_q <= '0;
    end else if (emit) begin
      if (pix_last) begin
        ci_q <= '0;
        cj_q <= '0;
      end else if (cj_q == two_half) begin
        ci_q <= ci_q + OFF_BITS'(1);
        cj_q <= '0;
      end else begin
        cj_q <= cj_q + OFF_BITS'(1);
      end
    end
  end

  // Current pixel
  localparam int PADO = CALC_BITS - OFF_BITS;
  logic                        done;
  logic [COORD_BITS-1:0]       cx, cy;
  logic signed [CALC_BITS-1:0] px, py;
  logic                        wr;

  assign done = (line_q.major_pos == line_q.major_end);
  assign cx   = line_q.steep ? line_q.minor_pos : line_q.major_pos;
  assign cy   = line_q.steep ? line_q.major_pos : line_q.minor_pos;
  assign px   = $signed({{PADW{1'b0}}, cx}) + $signed({{PADO{1'b0}}, ci_q})
                - $signed({{PADO{1'b0}}, half});
  assign py   = $signed({{PADW{1'b0}}, cy}) + $signed({{PADO{1'b0}}, cj_q})
                - $signed({{PADO{1'b0}}, half});
  assign wr   = (px >= x_lo) && (px < x_hi) && (py >= y_lo) && (py < y_hi);

  // Error term advance
  localparam int PADE = ERR_BITS - COORD_BITS;
  logic signed [ERR_BITS-1:0] err_sum;
  logic signed [ERR_BITS:0]   err_twice;
  logic                       minor_step;
  logic [COORD_BITS-1:0]      minor_next, major_next;

  assign err_sum    = err_q + $signed({{PADE{1'b0}}, line_q.minor_span});
  assign err_twice  = {err_sum, 1'b0};
  assign minor_step = err_twice >= $signed({{(PADE+1){1'b0}}, line_q.major_span});
  assign minor_next = line_q.minor_dir ? line_q.minor_pos - COORD_BITS'(1)
                                       : line_q.minor_pos + COORD_BITS'(1);
  assign major_next = line_q.major_dir ? line_q.major_pos - COORD_BITS'(1)
                                       : line_q.major_pos + COORD_BITS'(1);

  logic step_end;
  assign step_end = item_consume && !is_start && drawing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q    <= '0;
      err_q     <= '0;
      drawing_q <= 1'b0;
      color_q   <= '0;
    end else if (item_consume && is_start) begin
      line_q    <= setup;
      err_q     <= '0;
      drawing_q <= 1'b1;
      color_q   <= item_color_q;
    end else if (step_end) begin
      if (done) begin
        drawing_q <= 1'b0;
      end else begin
        line_q.major_pos <= major_next;
        if (minor_step) begin
          line_q.minor_pos <= minor_next;
          err_q            <= err_sum - $signed({{PADE{1'b0}}, line_q.major_span});
        end else begin
          err_q <= err_sum;
        end
      end
    end
  end

  // Output register
  logic                  m_valid_q, m_last_q, m_wr_q, m_done_q;
  logic [COORD_BITS-1:0] m_x_q, m_y_q;
  logic [COLOR_BITS-1:0] m_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_color_q <= color_q;
      m_last_q  <= pix_last;
      if (drawing_q) begin
        m_wr_q   <= wr;
        m_done_q <= done;
        m_x_q    <= wr ? px[COORD_BITS-1:0] : '0;
        m_y_q    <= wr ? py[COORD_BITS-1:0] : '0;
      end else begin
        m_wr_q   <= 1'b0;
        m_done_q <= 1'b1;
        m_x_q    <= '0;
        m_y_q    <= '0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_color_q, m_y_q, m_x_q};
  assign m_axis_tuser  = {m_done_q, m_wr_q};
  assign m_axis_tlast  = m_last_q;

  // Checks
  `CTLR_ASSERT_IMPLY(a_start_one_cycle, item_valid_q && is_start, item_consume,
    "start item not retired in one cycle")
  `CTLR_ASSERT_NEXT(a_draw_ends_with_last, item_consume && !is_start,
    m_valid_q && m_last_q, "draw item retired without a last transfer")
  `CTLR_ASSERT_IMPLY(a_offsets_in_square, item_valid_q,
    (ci_q <= two_half) && (cj_q <= two_half), "square offset out of range")
  `CTLR_ASSERT_IMPLY(a_nowrite_zero, m_valid_q && !m_wr_q,
    (m_x_q == '0) && (m_y_q == '0), "unwritten pixel with nonzero position")

endmodule
